### src/bdmc_pkg.sv
// Shared types, register indexes and reset values for the button debounce block.
`default_nettype none

package bdmc_pkg;

   // Widths of the timers, thresholds, click counters, register port and data channels.
   localparam int TimerWidth = 17;
   localparam int ThreshWidth = 16;
   localparam int CountWidth = 8;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 16;
   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 8;

   localparam logic [TimerWidth-1:0] TimerMax = {TimerWidth{1'b1}};
   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   // Configuration register indexes.
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEBOUNCE_TICKS = 3'd0,
      CSR_CLICK_TIMEOUT = 3'd1,
      CSR_INVERT_INPUT = 3'd2,
      CSR_PRESS_TARGET = 3'd3,
      CSR_RELEASE_TARGET = 3'd4
   } csr_index_type;

   // Values of the configuration registers after reset.
   localparam logic [ThreshWidth-1:0] DebounceReset = 16'd20;
   localparam logic [ThreshWidth-1:0] TimeoutReset = 16'd300;
   localparam logic InvertReset = 1'b1;
   localparam logic [CountWidth-1:0] PressTargetReset = 8'd2;
   localparam logic [CountWidth-1:0] ReleaseTargetReset = 8'd2;

   // Configuration register set.
   typedef struct packed {
      logic [ThreshWidth-1:0] debounce_ticks;
      logic [ThreshWidth-1:0] click_timeout_ticks;
      logic invert_input;
      logic [CountWidth-1:0] press_click_target;
      logic [CountWidth-1:0] release_click_target;
   } cfg_type;

   // Next state of one click counter and its hit flag.
   typedef struct packed {
      logic [TimerWidth-1:0] timer;
      logic [CountWidth-1:0] count;
      logic hit;
   } click_result_type;

endpackage

`default_nettype wire

### src/button_debounce_multi_click_core.sv
// Button debounce with edge, toggle and multi-click detection, one item per tick.
//
//  Channel | Direction | Ports                              | Contents
//  req     | in        | req_tvalid, req_tready, req_tdata  | raw_level in bit 0
//  rsp     | out       | rsp_tvalid, rsp_tready, rsp_tdata  | eight result flags
//  csr     | in        | csr_valid, csr_ready, csr_index,   | register index and value
//          |           | csr_data                           |
//
// Each tick item is handled at the edge where it is accepted: the state
// registers and the result register are updated at that edge.
// A new item is accepted every cycle while the result register is empty or
// being taken, so the sustained rate is one item per cycle.
// Reset is synchronous and active high; it clears all state but the result data and
// restores the register defaults. A stalled result holds, and input waits only then.
`default_nettype none

module button_debounce_multi_click_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // Bit 0: raw_level; bits 7:1: zero.
   input  wire logic [bdmc_pkg::ReqDataWidth-1:0] req_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // Bit 0: press_edge, 1: release_edge, 2: held, 3: level_changed,
   // 4: press_toggle, 5: release_toggle, 6: multi_press_hit, 7: multi_release_hit.
   output logic [bdmc_pkg::RspDataWidth-1:0] rsp_tdata,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [bdmc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [bdmc_pkg::CsrDataWidth-1:0] csr_data
);
   import bdmc_pkg::*;

   // One click counter step: counts timely edges, restarts after a late one,
   // clears after the timeout and on reaching its target.
   function automatic click_result_type click_step(
      input logic evt,
      input logic [TimerWidth-1:0] timer,
      input logic [CountWidth-1:0] count,
      input logic [CountWidth-1:0] target,
      input logic [ThreshWidth-1:0] timeout
   );
      click_result_type r;
      logic [TimerWidth-1:0] elapsed;
      logic late;
      elapsed = (timer == TimerMax) ? TimerMax : timer + {{(TimerWidth-1){1'b0}}, 1'b1};
      late = elapsed > {1'b0, timeout};
      r.count = count;
      if (!evt) begin
         if (late) begin
            r.count = '0;
         end
         r.timer = elapsed;
      end else begin
         if (!late) begin
            r.count = (count == CountMax) ? CountMax : count + {{(CountWidth-1){1'b0}}, 1'b1};
         end else begin
            r.count = {{(CountWidth-1){1'b0}}, 1'b1};
         end
         r.timer = '0;
      end
      r.hit = (r.count == target);
      if (r.hit) begin
         r.count = '0;
      end
      return r;
   endfunction

   cfg_type cfg_ff;
   logic [TimerWidth-1:0] sample_timer_ff, sample_timer_in;
   logic now_ff, now_in;
   logic before_ff, before_in;
   logic press_toggle_ff, press_toggle_in;
   logic release_toggle_ff, release_toggle_in;
   logic [TimerWidth-1:0] press_timer_ff;
   logic [TimerWidth-1:0] release_timer_ff;
   logic [CountWidth-1:0] press_count_ff;
   logic [CountWidth-1:0] release_count_ff;
   logic rsp_valid_ff;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic level;
   logic [TimerWidth-1:0] sample_elapsed;
   logic sample;
   logic changed_in;
   logic press_edge_in;
   logic release_edge_in;
   click_result_type press_res;
   click_result_type release_res;

   // Handshakes: the result register parts the two sides.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // Resample the corrected level once more than the debounce time has passed.
   always_comb begin
      level = req_tdata[0] ^ cfg_ff.invert_input;
      sample_elapsed = (sample_timer_ff == TimerMax) ? TimerMax
                     : sample_timer_ff + {{(TimerWidth-1){1'b0}}, 1'b1};
      sample = sample_elapsed > {1'b0, cfg_ff.debounce_ticks};
      if (sample) begin
         before_in = now_ff;
         now_in = level;
         sample_timer_in = '0;
      end else begin
         before_in = before_ff;
         now_in = now_ff;
         sample_timer_in = sample_elapsed;
      end
      changed_in = sample && (now_in != before_in);
      press_edge_in = changed_in && now_in && !before_in;
      release_edge_in = changed_in && !now_in && before_in;
      press_toggle_in = press_toggle_ff ^ press_edge_in;
      release_toggle_in = release_toggle_ff ^ release_edge_in;
   end

   // Click counters for presses and releases.
   always_comb begin
      press_res = click_step(press_edge_in, press_timer_ff, press_count_ff,
                             cfg_ff.press_click_target, cfg_ff.click_timeout_ticks);
      release_res = click_step(release_edge_in, release_timer_ff, release_count_ff,
                               cfg_ff.release_click_target, cfg_ff.click_timeout_ticks);
   end

   // Result item packing, highest bit first.
   assign rsp_data_in = {release_res.hit, press_res.hit, release_toggle_in,
                         press_toggle_in, changed_in, now_in, release_edge_in,
                         press_edge_in};

   // State, configuration and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DebounceReset;
         cfg_ff.click_timeout_ticks <= TimeoutReset;
         cfg_ff.invert_input <= InvertReset;
         cfg_ff.press_click_target <= PressTargetReset;
         cfg_ff.release_click_target <= ReleaseTargetReset;
         sample_timer_ff <= '0;
         now_ff <= 1'b0;
         before_ff <= 1'b0;
         press_toggle_ff <= 1'b0;
         release_toggle_ff <= 1'b0;
         press_timer_ff <= '0;
         release_timer_ff <= '0;
         press_count_ff <= '0;
         release_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE_TICKS: cfg_ff.debounce_ticks <= csr_data;
               CSR_CLICK_TIMEOUT: cfg_ff.click_timeout_ticks <= csr_data;
               CSR_INVERT_INPUT: cfg_ff.invert_input <= csr_data[0];
               CSR_PRESS_TARGET: cfg_ff.press_click_target <= csr_data[CountWidth-1:0];
               CSR_RELEASE_TARGET: cfg_ff.release_click_target <= csr_data[CountWidth-1:0];
               default: begin
               end
            endcase
         end
         if (req_accept) begin
            sample_timer_ff <= sample_timer_in;
            now_ff <= now_in;
            before_ff <= before_in;
            press_toggle_ff <= press_toggle_in;
            release_toggle_ff <= release_toggle_in;
            press_timer_ff <= press_res.timer;
            release_timer_ff <= release_res.timer;
            press_count_ff <= press_res.count;
            release_count_ff <= release_res.count;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A press edge always reports a change to the pressed level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[3] && rsp_tdata[2] && !rsp_tdata[1])
      else $error("press edge without a change to pressed");

   // A release edge always reports a change to the released level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[3] && !rsp_tdata[2])
      else $error("release edge without a change to released");

   // The press toggle flips exactly on accepted press edges.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (press_toggle_ff != $past(press_toggle_ff)) == $past(press_edge_in))
      else $error("press toggle out of step with press edges");

   // A hit clears its click counter.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && press_res.hit |=> press_count_ff == '0)
      else $error("press count not cleared after hit");

   // A change is only reported on a sampling tick, which restarts the timer.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && changed_in |=> sample_timer_ff == '0)
      else $error("level change without sample timer restart");

endmodule

`default_nettype wire
